>>> rtl/thumbnail_fit_geometry_assert.svh
// Assertion macros for the thumbnail geometry block.
// Included by the top level; relies on clock and reset in the including scope.
`ifndef THUMBNAIL_FIT_GEOMETRY_ASSERT_SVH
`define THUMBNAIL_FIT_GEOMETRY_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TFG_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("thumbnail_fit_geometry: check failed");

// Next-cycle implication, disabled during reset.
`define TFG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("thumbnail_fit_geometry: check failed");

`endif

>>> rtl/tfg_pkg.sv
// Shared constants and types of the thumbnail geometry block.
// No dependencies.
`default_nettype none
package tfg_pkg;
   localparam int DIM_BITS_DEF = 16;
   localparam int LIM_BITS = 20;
   localparam int UNLIMITED_SIDE = 1000000;
   localparam logic [15:0] MARK_MIN_RESET = 16'd200;
   localparam logic [7:0] MARK_MARGIN_RESET = 8'd10;

   localparam logic [1:0] CMD_SCALE = 2'd0;
   localparam logic [1:0] CMD_CROP = 2'd1;
   localparam logic [1:0] CMD_FILL = 2'd2;
   localparam logic [1:0] CMD_NONE = 2'd3;

   localparam logic REG_MARK_MIN = 1'b0;
   localparam logic REG_MARK_MARGIN = 1'b1;

   typedef struct packed {
      logic [1:0] cmd;
      logic       g_top;
      logic       g_bottom;
      logic       g_left;
      logic       g_right;
      logic       mark_allowed;
      logic       bad;
      logic       resized;
      logic       width_case;
   } ctl_type;
endpackage
`default_nettype wire

>>> rtl/tfg_setup.sv
// Front stages: box limits, cross products, resize decision and divider seed.
// Depends on tfg_pkg.
`default_nettype none
module tfg_setup #(
   parameter int DIM_BITS = tfg_pkg::DIM_BITS_DEF
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         adv,
   input  wire                         in_valid,
   input  tfg_pkg::ctl_type            in_ctl,
   input  wire [DIM_BITS-1:0]          src_w,
   input  wire [DIM_BITS-1:0]          src_h,
   input  wire [DIM_BITS-1:0]          box_w,
   input  wire [DIM_BITS-1:0]          box_h,
   input  wire [DIM_BITS-1:0]          mark_w,
   input  wire [DIM_BITS-1:0]          mark_h,
   output logic                        stage_a_valid,
   output logic                        out_valid,
   output tfg_pkg::ctl_type            out_ctl,
   output logic [7*DIM_BITS-1:0]       out_ctx,
   output logic [DIM_BITS:0]           out_rem,
   output logic [DIM_BITS:0]           out_low,
   output logic [DIM_BITS:0]           out_div
);
   import tfg_pkg::*;

   localparam int LW = (DIM_BITS > LIM_BITS) ? DIM_BITS : LIM_BITS;
   localparam int PW = LW + DIM_BITS;
   localparam int NW = PW + 2;
   localparam int QW = DIM_BITS + 1;

   logic [LW-1:0] lw_c, lh_c;
   logic          res_c, bad_c;
   ctl_type       ctl_c;

   logic                va_ff;
   ctl_type             ctla_ff;
   logic [DIM_BITS-1:0] wa_ff, ha_ff, bwa_ff, bha_ff, mwa_ff, mha_ff, lwa_ff, lha_ff;
   logic [PW-1:0]       m1_ff, m2_ff;

   logic          wc_c;
   logic [PW-1:0] n_c;
   logic [DIM_BITS-1:0] d_c, fix_c;
   logic [NW-1:0] num_c;
   ctl_type       ctlb_c;

   logic                vb_ff;
   ctl_type             ctlb_ff;
   logic [7*DIM_BITS-1:0] ctx_ff;
   logic [QW-1:0]       rem_ff, low_ff, div_ff;

   always_comb begin
      lw_c = ((in_ctl.cmd == CMD_SCALE) && (box_w == '0)) ? LW'(UNLIMITED_SIDE) : LW'(box_w);
      lh_c = ((in_ctl.cmd == CMD_SCALE) && (box_h == '0)) ? LW'(UNLIMITED_SIDE) : LW'(box_h);
      bad_c = (src_w == '0) || (src_h == '0);
      case (in_ctl.cmd)
         CMD_SCALE: res_c = (LW'(src_w) > lw_c) || (LW'(src_h) > lh_c);
         CMD_CROP:  res_c = (box_w < src_w) && (box_h < src_h);
         CMD_FILL:  res_c = (src_w > box_w) || (src_h > box_h);
         default:   res_c = 1'b0;
      endcase
      ctl_c = in_ctl;
      ctl_c.bad = bad_c;
      ctl_c.resized = res_c && !bad_c;
      ctl_c.width_case = 1'b0;
   end

   // Stage A: products and decision.
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= in_valid;
      end
      if (adv) begin
         ctla_ff <= ctl_c;
         wa_ff <= src_w;
         ha_ff <= src_h;
         bwa_ff <= box_w;
         bha_ff <= box_h;
         mwa_ff <= mark_w;
         mha_ff <= mark_h;
         lwa_ff <= lw_c[DIM_BITS-1:0];
         lha_ff <= lh_c[DIM_BITS-1:0];
         m1_ff <= PW'(lw_c) * PW'(src_h);
         m2_ff <= PW'(lh_c) * PW'(src_w);
      end
   end

   always_comb begin
      wc_c = (ctla_ff.cmd == CMD_CROP) ? (m1_ff >= m2_ff) : (m1_ff < m2_ff);
      n_c = wc_c ? m1_ff : m2_ff;
      d_c = wc_c ? wa_ff : ha_ff;
      fix_c = wc_c ? lwa_ff : lha_ff;
      num_c = NW'({n_c, 1'b0}) + NW'(d_c);
      ctlb_c = ctla_ff;
      ctlb_c.width_case = wc_c;
   end

   // Stage B: seed of the rounded division (2n+d)/(2d).
   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (adv) begin
         vb_ff <= va_ff;
      end
      if (adv) begin
         ctlb_ff <= ctlb_c;
         ctx_ff <= {fix_c, mha_ff, mwa_ff, bha_ff, bwa_ff, ha_ff, wa_ff};
         rem_ff <= num_c[2*QW-1:QW];
         low_ff <= num_c[QW-1:0];
         div_ff <= {d_c, 1'b0};
      end
   end

   assign stage_a_valid = va_ff;
   assign out_valid = vb_ff;
   assign out_ctl = ctlb_ff;
   assign out_ctx = ctx_ff;
   assign out_rem = rem_ff;
   assign out_low = low_ff;
   assign out_div = div_ff;
endmodule
`default_nettype wire

>>> rtl/tfg_div_cell.sv
// One restoring-division cell: resolves one quotient bit and passes the item on.
// Depends on tfg_pkg.
`default_nettype none
module tfg_div_cell #(
   parameter int DIM_BITS = tfg_pkg::DIM_BITS_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     adv,
   input  wire                     in_valid,
   input  tfg_pkg::ctl_type        in_ctl,
   input  wire [7*DIM_BITS-1:0]    in_ctx,
   input  wire [DIM_BITS:0]        in_rem,
   input  wire [DIM_BITS:0]        in_low,
   input  wire [DIM_BITS:0]        in_div,
   output logic                    out_valid,
   output tfg_pkg::ctl_type        out_ctl,
   output logic [7*DIM_BITS-1:0]   out_ctx,
   output logic [DIM_BITS:0]       out_rem,
   output logic [DIM_BITS:0]       out_low,
   output logic [DIM_BITS:0]       out_div
);
   import tfg_pkg::*;

   localparam int QW = DIM_BITS + 1;

   logic [QW:0]   trial;
   logic          ge;
   logic [QW-1:0] rem_in;

   logic                  valid_ff;
   ctl_type               ctl_ff;
   logic [7*DIM_BITS-1:0] ctx_ff;
   logic [QW-1:0]         rem_ff, low_ff, div_ff;

   always_comb begin
      trial = {in_rem, in_low[QW-1]};
      ge = trial >= {1'b0, in_div};
      rem_in = ge ? QW'(trial - {1'b0, in_div}) : trial[QW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         ctl_ff <= in_ctl;
         ctx_ff <= in_ctx;
         rem_ff <= rem_in;
         low_ff <= {in_low[QW-2:0], ge};
         div_ff <= in_div;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl = ctl_ff;
   assign out_ctx = ctx_ff;
   assign out_rem = rem_ff;
   assign out_low = low_ff;
   assign out_div = div_ff;
endmodule
`default_nettype wire

>>> rtl/tfg_finish.sv
// Back stages: resize sides, canvas extent and gravity offsets, watermark placement.
// Depends on tfg_pkg.
`default_nettype none
module tfg_finish #(
   parameter int DIM_BITS = tfg_pkg::DIM_BITS_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     adv,
   input  wire [15:0]              mark_min,
   input  wire [7:0]               mark_margin,
   input  wire                     in_valid,
   input  tfg_pkg::ctl_type        in_ctl,
   input  wire [7*DIM_BITS-1:0]    in_ctx,
   input  wire [DIM_BITS:0]        in_quot,
   output logic                    out_valid,
   output logic                    bad_size,
   output logic                    resized,
   output logic [DIM_BITS-1:0]     resize_width,
   output logic [DIM_BITS-1:0]     resize_height,
   output logic                    extended,
   output logic [DIM_BITS:0]       canvas_dx,
   output logic [DIM_BITS:0]       canvas_dy,
   output logic [DIM_BITS-1:0]     final_width,
   output logic [DIM_BITS-1:0]     final_height,
   output logic                    watermarked,
   output logic [DIM_BITS:0]       mark_x,
   output logic [DIM_BITS:0]       mark_y
);
   import tfg_pkg::*;

   localparam int D = DIM_BITS;
   localparam int MW = (DIM_BITS > 16) ? DIM_BITS : 16;

   function automatic logic [DIM_BITS:0] grav_off(input logic near, input logic far,
                                                  input logic [DIM_BITS-1:0] box,
                                                  input logic [DIM_BITS-1:0] size);
      logic signed [DIM_BITS+1:0] gap;
      logic signed [DIM_BITS+1:0] half;
      logic signed [DIM_BITS+1:0] res;
      gap = $signed({2'b00, box}) - $signed({2'b00, size});
      // Halve with truncation toward zero.
      half = (gap + $signed({{(DIM_BITS+1){1'b0}}, gap[DIM_BITS+1]})) >>> 1;
      if (near) res = '0;
      else if (far) res = -gap;
      else res = -half;
      return res[DIM_BITS:0];
   endfunction

   logic [D-1:0] w, h, bw, bh, mw, mh, fix, q;
   logic [D-1:0] rw_c, rh_c, cw_c, ch_c, fw_c, fh_c;
   logic         ext_c;
   logic [D:0]   ox_c, oy_c;

   logic         v1_ff, bad1_ff, res1_ff, ext1_ff, allow1_ff;
   logic [D-1:0] rw1_ff, rh1_ff, fw1_ff, fh1_ff, mw1_ff, mh1_ff;
   logic [D:0]   ox1_ff, oy1_ff;

   logic         wm_c;
   logic [D+1:0] mx_c, my_c;

   logic         v2_ff, bad2_ff, res2_ff, ext2_ff, wm2_ff;
   logic [D-1:0] rw2_ff, rh2_ff, fw2_ff, fh2_ff;
   logic [D:0]   ox2_ff, oy2_ff, mx2_ff, my2_ff;

   always_comb begin
      {fix, mh, mw, bh, bw, h, w} = in_ctx;
      q = in_quot[D-1:0];
      rw_c = in_ctl.resized ? (in_ctl.width_case ? fix : q) : '0;
      rh_c = in_ctl.resized ? (in_ctl.width_case ? q : fix) : '0;
      cw_c = in_ctl.resized ? rw_c : w;
      ch_c = in_ctl.resized ? rh_c : h;
      ext_c = ((in_ctl.cmd == CMD_CROP) || (in_ctl.cmd == CMD_FILL)) &&
              ((cw_c != bw) || (ch_c != bh)) && !in_ctl.bad;
      ox_c = ext_c ? grav_off(in_ctl.g_left, in_ctl.g_right, bw, cw_c) : '0;
      oy_c = ext_c ? grav_off(in_ctl.g_top, in_ctl.g_bottom, bh, ch_c) : '0;
      fw_c = in_ctl.bad ? '0 : (ext_c ? bw : cw_c);
      fh_c = in_ctl.bad ? '0 : (ext_c ? bh : ch_c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
      end
      if (adv) begin
         bad1_ff <= in_ctl.bad;
         res1_ff <= in_ctl.resized;
         rw1_ff <= rw_c;
         rh1_ff <= rh_c;
         ext1_ff <= ext_c;
         ox1_ff <= ox_c;
         oy1_ff <= oy_c;
         fw1_ff <= fw_c;
         fh1_ff <= fh_c;
         allow1_ff <= in_ctl.mark_allowed && !in_ctl.bad;
         mw1_ff <= mw;
         mh1_ff <= mh;
      end
   end

   always_comb begin
      wm_c = allow1_ff &&
             (MW'(fw1_ff) >= MW'(mark_min)) && (MW'(fh1_ff) >= MW'(mark_min)) &&
             ({1'b0, fw1_ff} >= {mw1_ff, 1'b0}) && ({1'b0, fh1_ff} >= {mh1_ff, 1'b0});
      mx_c = (D+2)'(fw1_ff) - (D+2)'(mw1_ff) - (D+2)'(mark_margin);
      my_c = (D+2)'(fh1_ff) - (D+2)'(mh1_ff) - (D+2)'(mark_margin);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         bad2_ff <= bad1_ff;
         res2_ff <= res1_ff;
         rw2_ff <= rw1_ff;
         rh2_ff <= rh1_ff;
         ext2_ff <= ext1_ff;
         ox2_ff <= ox1_ff;
         oy2_ff <= oy1_ff;
         fw2_ff <= fw1_ff;
         fh2_ff <= fh1_ff;
         wm2_ff <= wm_c;
         mx2_ff <= wm_c ? mx_c[D:0] : '0;
         my2_ff <= wm_c ? my_c[D:0] : '0;
      end
   end

   assign out_valid = v2_ff;
   assign bad_size = bad2_ff;
   assign resized = res2_ff;
   assign resize_width = rw2_ff;
   assign resize_height = rh2_ff;
   assign extended = ext2_ff;
   assign canvas_dx = ox2_ff;
   assign canvas_dy = oy2_ff;
   assign final_width = fw2_ff;
   assign final_height = fh2_ff;
   assign watermarked = wm2_ff;
   assign mark_x = mx2_ff;
   assign mark_y = my2_ff;
endmodule
`default_nettype wire

>>> rtl/thumbnail_fit_geometry.sv
// Thumbnail fit geometry, top level. Each request transaction carries a source image
// size, a mode (scale to fit, scale and crop, scale and fill) and a target box; the
// response transaction gives the resize size, canvas extent and gravity offset, the
// final size and the watermark position. The block takes one request per clock unless
// the response is stalled, and returns one response per request, in order, through
// two setup stages (cross products, then divider seed), a row of DIM_BITS+1 division
// cells that each settle one quotient bit of the round-half-up division, and two
// finishing stages whose last register is the response register. The whole row
// advances together whenever the response register is empty or being taken, so a
// stalled response holds every stage. Depends on tfg_pkg, tfg_setup, tfg_div_cell,
// tfg_finish and thumbnail_fit_geometry_assert.svh.
`default_nettype none
module thumbnail_fit_geometry #(
   parameter int DIM_BITS = tfg_pkg::DIM_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   // req_tdata: src_width, src_height, box_width, box_height, anchor top,
   // anchor bottom, anchor left, anchor right, mark_allowed, mark_width, mark_height
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire [((6*DIM_BITS+5+7)/8)*8-1:0] req_tdata,
   // req_tuser: command
   input  wire [1:0]                        req_tuser,
   // rsp_tdata: resized, resize_width, resize_height, extended, canvas x shift,
   // canvas y shift, final_width, final_height, watermarked, mark_x, mark_y
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [((8*DIM_BITS+7+7)/8)*8-1:0] rsp_tdata,
   // rsp_tuser: bad_size
   output logic                             rsp_tuser,
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire [2:0]                        csr_paddr,
   input  wire [31:0]                       csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import tfg_pkg::*;

   localparam int D = DIM_BITS;
   localparam int QW = DIM_BITS + 1;
   localparam int REQ_W = ((6*DIM_BITS+5+7)/8)*8;
   localparam int RSP_W = ((8*DIM_BITS+7+7)/8)*8;
   localparam int RSP_USED = 8*DIM_BITS+7;

   logic [15:0] mark_min_ff, mark_min_in;
   logic [7:0]  mark_margin_ff, mark_margin_in;
   logic        csr_wr;
   logic        adv;

   ctl_type             req_ctl;
   logic [D-1:0]        sw, sh, bw, bh, mw, mh;
   logic                stage_a_valid;

   logic                  c_valid [0:QW];
   ctl_type               c_ctl   [0:QW];
   logic [7*D-1:0]        c_ctx   [0:QW];
   logic [QW-1:0]         c_rem   [0:QW];
   logic [QW-1:0]         c_low   [0:QW];
   logic [QW-1:0]         c_div   [0:QW];

   logic          f_bad, f_res, f_ext, f_wm;
   logic [D-1:0]  f_rw, f_rh, f_fw, f_fh;
   logic [D:0]    f_ox, f_oy, f_mx, f_my;

   // Configuration: write at the access phase, low address bits ignored.
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      mark_min_in = mark_min_ff;
      mark_margin_in = mark_margin_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_MARK_MIN:    mark_min_in = csr_pwdata[15:0];
            REG_MARK_MARGIN: mark_margin_in = csr_pwdata[7:0];
            default:         mark_min_in = mark_min_ff;
         endcase
      end
      case (csr_paddr[2])
         REG_MARK_MIN:    csr_prdata = {16'd0, mark_min_ff};
         REG_MARK_MARGIN: csr_prdata = {24'd0, mark_margin_ff};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_min_ff <= MARK_MIN_RESET;
         mark_margin_ff <= MARK_MARGIN_RESET;
      end else begin
         mark_min_ff <= mark_min_in;
         mark_margin_ff <= mark_margin_in;
      end
   end

   // Advance the whole row whenever the response register can take a new item.
   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // Unpack the request.
   always_comb begin
      sw = req_tdata[0*D +: D];
      sh = req_tdata[1*D +: D];
      bw = req_tdata[2*D +: D];
      bh = req_tdata[3*D +: D];
      req_ctl = '0;
      req_ctl.cmd = req_tuser;
      req_ctl.g_top = req_tdata[4*D];
      req_ctl.g_bottom = req_tdata[4*D+1];
      req_ctl.g_left = req_tdata[4*D+2];
      req_ctl.g_right = req_tdata[4*D+3];
      req_ctl.mark_allowed = req_tdata[4*D+4];
      mw = req_tdata[4*D+5 +: D];
      mh = req_tdata[5*D+5 +: D];
   end

   tfg_setup #(.DIM_BITS(DIM_BITS)) u_setup (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_valid      (req_tvalid),
      .in_ctl        (req_ctl),
      .src_w         (sw),
      .src_h         (sh),
      .box_w         (bw),
      .box_h         (bh),
      .mark_w        (mw),
      .mark_h        (mh),
      .stage_a_valid (stage_a_valid),
      .out_valid     (c_valid[0]),
      .out_ctl       (c_ctl[0]),
      .out_ctx       (c_ctx[0]),
      .out_rem       (c_rem[0]),
      .out_low       (c_low[0]),
      .out_div       (c_div[0])
   );

   // Division row: one cell per quotient bit, most significant first.
   for (genvar i = 0; i < QW; i++) begin : g_cell
      tfg_div_cell #(.DIM_BITS(DIM_BITS)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (c_valid[i]),
         .in_ctl    (c_ctl[i]),
         .in_ctx    (c_ctx[i]),
         .in_rem    (c_rem[i]),
         .in_low    (c_low[i]),
         .in_div    (c_div[i]),
         .out_valid (c_valid[i+1]),
         .out_ctl   (c_ctl[i+1]),
         .out_ctx   (c_ctx[i+1]),
         .out_rem   (c_rem[i+1]),
         .out_low   (c_low[i+1]),
         .out_div   (c_div[i+1])
      );
   end

   tfg_finish #(.DIM_BITS(DIM_BITS)) u_finish (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .mark_min      (mark_min_ff),
      .mark_margin   (mark_margin_ff),
      .in_valid      (c_valid[QW]),
      .in_ctl        (c_ctl[QW]),
      .in_ctx        (c_ctx[QW]),
      .in_quot       (c_low[QW]),
      .out_valid     (rsp_tvalid),
      .bad_size      (f_bad),
      .resized       (f_res),
      .resize_width  (f_rw),
      .resize_height (f_rh),
      .extended      (f_ext),
      .canvas_dx     (f_ox),
      .canvas_dy     (f_oy),
      .final_width   (f_fw),
      .final_height  (f_fh),
      .watermarked   (f_wm),
      .mark_x        (f_mx),
      .mark_y        (f_my)
   );

   // Pack the response, first field lowest.
   assign rsp_tdata = RSP_W'({f_my, f_mx, f_wm, f_fh, f_fw, f_oy, f_ox, f_ext,
                              f_rh, f_rw, f_res});
   assign rsp_tuser = f_bad;

   `include "thumbnail_fit_geometry_assert.svh"

   `TFG_ASSERT_IMPLIES(a_bad_clears, rsp_tvalid && rsp_tuser, rsp_tdata[RSP_USED-1:0] == '0)
   `TFG_ASSERT_IMPLIES(a_mark_min, rsp_tvalid && f_wm, (32'(f_fw) >= 32'(mark_min_ff)) && (32'(f_fh) >= 32'(mark_min_ff)))
   `TFG_ASSERT_NEXT(a_accept_enters, req_tvalid && req_tready, stage_a_valid)
   `TFG_ASSERT_IMPLIES(a_no_resize_zero, rsp_tvalid && !f_res, (f_rw == '0) && (f_rh == '0))

   logic unused_req;
   assign unused_req = ^{req_tdata[REQ_W-1:6*D+5], csr_paddr[1:0], csr_pwdata[31:16]};
endmodule
`default_nettype wire
